/* design/yuyv2rgba_pkg.sv */
// Shared types, codes and constants for the YUYV 4:2:2 to RGBA converter.
// No dependencies.

package yuyv2rgba_pkg;

   typedef enum logic {
      MODE_INTEGER = 1'b0,
      MODE_FIXED   = 1'b1
   } mode_type;

   typedef enum logic {
      CSR_MODE  = 1'b0,
      CSR_ALPHA = 1'b1
   } csr_index_type;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned INT_W    = 16;
   localparam int unsigned FIX_W    = 26;
   localparam int unsigned OFF_W    = 10;
   localparam int unsigned INT_SHIFT = 6;
   localparam int unsigned FIX_SHIFT = 16;

   localparam logic [BYTE_W-1:0] ALPHA_RESET = 8'hff;

   localparam logic signed [INT_W-1:0] INT_V_RED   = 16'sd90;
   localparam logic signed [INT_W-1:0] INT_U_GREEN = -16'sd22;
   localparam logic signed [INT_W-1:0] INT_V_GREEN = -16'sd46;
   localparam logic signed [INT_W-1:0] INT_U_BLUE  = 16'sd113;

   localparam logic signed [FIX_W-1:0] FIX_V_RED   = 26'sd92242;
   localparam logic signed [FIX_W-1:0] FIX_U_GREEN = -26'sd22580;
   localparam logic signed [FIX_W-1:0] FIX_V_GREEN = -26'sd46983;
   localparam logic signed [FIX_W-1:0] FIX_U_BLUE  = 26'sd116589;

   typedef struct packed {
      logic [BYTE_W-1:0] red_first;
      logic [BYTE_W-1:0] green_first;
      logic [BYTE_W-1:0] blue_first;
      logic [BYTE_W-1:0] red_second;
      logic [BYTE_W-1:0] green_second;
      logic [BYTE_W-1:0] blue_second;
   } pixel_pair_type;

   function automatic logic [BYTE_W-1:0] clamp_byte(input logic [BYTE_W-1:0] luma,
                                                     input logic signed [OFF_W-1:0] offset);
      logic signed [OFF_W:0] sum;
      sum = $signed({3'b000, luma}) + $signed({offset[OFF_W-1], offset});
      if (sum[OFF_W]) begin
         return '0;
      end else if (sum[OFF_W-1:BYTE_W] != '0) begin
         return '1;
      end else begin
         return sum[BYTE_W-1:0];
      end
   endfunction

endpackage

/* design/yuyv_to_rgba_convert.sv */
// Top level of the YUYV 4:2:2 to RGBA converter: handshake, input and result registers, CSRs.
// Depends on yuyv2rgba_pkg and yuyv2rgba_core.
//
// Each accepted item is one YUYV macropixel (Y0, U, Y1, V) plus an end-of-frame flag; each
// result item holds two clamped RGB pixels, the common alpha and the flag. The block takes one
// item per clock while req_stall is low: an item is captured in the input register, converted
// combinationally by the color math and held in the result register, and a new item can enter
// while a finished result waits on rsp_stall. conversion_mode (0 integer 1/64 coefficients,
// 1 Q16 coefficients) and alpha_level are written through the CSR port; the user must write
// them only while no items are in flight, as the block itself does not enforce this.

module yuyv_to_rgba_convert (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [7:0]  csr_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_luma_first,
   input  logic [7:0]  req_chroma_blue,
   input  logic [7:0]  req_luma_second,
   input  logic [7:0]  req_chroma_red,
   input  logic        req_frame_end_in,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red_first,
   output logic [7:0]  rsp_green_first,
   output logic [7:0]  rsp_blue_first,
   output logic [7:0]  rsp_red_second,
   output logic [7:0]  rsp_green_second,
   output logic [7:0]  rsp_blue_second,
   output logic [7:0]  rsp_alpha_out,
   output logic        rsp_frame_end_out
);
   import yuyv2rgba_pkg::*;

   mode_type          mode_ff, mode_in;
   logic [BYTE_W-1:0] alpha_ff, alpha_in;

   logic              a_vld_ff, a_vld_in;
   logic [BYTE_W-1:0] a_y0_ff, a_u_ff, a_y1_ff, a_v_ff;
   logic              a_end_ff;

   logic              r_vld_ff, r_vld_in;
   pixel_pair_type    r_pix_ff;
   logic [BYTE_W-1:0] r_alpha_ff;
   logic              r_end_ff;

   pixel_pair_type    pix;
   logic              a_load;
   logic              r_load;

   // CSRs
   always_comb begin
      mode_in  = mode_ff;
      alpha_in = alpha_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:  mode_in  = mode_type'(csr_data[0]);
            CSR_ALPHA: alpha_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_INTEGER;
         alpha_ff <= ALPHA_RESET;
      end else begin
         mode_ff  <= mode_in;
         alpha_ff <= alpha_in;
      end
   end

   // handshake
   assign r_load    = a_vld_ff && (!r_vld_ff || !rsp_stall);
   assign req_stall = a_vld_ff && !r_load;
   assign a_load    = req_valid && !req_stall;

   always_comb begin
      if (a_load) begin
         a_vld_in = 1'b1;
      end else if (r_load) begin
         a_vld_in = 1'b0;
      end else begin
         a_vld_in = a_vld_ff;
      end
   end

   always_comb begin
      if (r_load) begin
         r_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         r_vld_in = 1'b0;
      end else begin
         r_vld_in = r_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         r_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         r_vld_ff <= r_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_y0_ff  <= req_luma_first;
         a_u_ff   <= req_chroma_blue;
         a_y1_ff  <= req_luma_second;
         a_v_ff   <= req_chroma_red;
         a_end_ff <= req_frame_end_in;
      end
   end

   yuyv2rgba_core u_core (
      .mode        (mode_ff),
      .luma_first  (a_y0_ff),
      .chroma_blue (a_u_ff),
      .luma_second (a_y1_ff),
      .chroma_red  (a_v_ff),
      .pixels      (pix)
   );

   always_ff @(posedge clock) begin
      if (r_load) begin
         r_pix_ff   <= pix;
         r_alpha_ff <= alpha_ff;
         r_end_ff   <= a_end_ff;
      end
   end

   assign rsp_valid         = r_vld_ff;
   assign rsp_red_first     = r_pix_ff.red_first;
   assign rsp_green_first   = r_pix_ff.green_first;
   assign rsp_blue_first    = r_pix_ff.blue_first;
   assign rsp_red_second    = r_pix_ff.red_second;
   assign rsp_green_second  = r_pix_ff.green_second;
   assign rsp_blue_second   = r_pix_ff.blue_second;
   assign rsp_alpha_out     = r_alpha_ff;
   assign rsp_frame_end_out = r_end_ff;

   // checks
   a_result_loaded : assert property (@(posedge clock) disable iff (reset)
      r_load |=> rsp_valid)
      else $error("result register load did not raise rsp_valid");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_vld_ff && r_vld_ff && rsp_stall))
      else $error("input stalled while the pipeline could advance");

   a_item_kept : assert property (@(posedge clock) disable iff (reset)
      (a_vld_ff && !r_load) |=> a_vld_ff)
      else $error("item dropped from the input register");

   a_item_to_result : assert property (@(posedge clock) disable iff (reset)
      (a_vld_ff && r_vld_ff && !rsp_stall) |=> r_vld_ff)
      else $error("result register emptied while an item was waiting");

endmodule

/* design/yuyv2rgba_core.sv */
// Color math for one macropixel: chroma offsets for both modes, luma add and clamp.
// Depends on yuyv2rgba_pkg.

module yuyv2rgba_core (
   input  yuyv2rgba_pkg::mode_type       mode,
   input  logic [7:0]                    luma_first,
   input  logic [7:0]                    chroma_blue,
   input  logic [7:0]                    luma_second,
   input  logic [7:0]                    chroma_red,
   output yuyv2rgba_pkg::pixel_pair_type pixels
);
   import yuyv2rgba_pkg::*;

   logic signed [BYTE_W-1:0] u_s;
   logic signed [BYTE_W-1:0] v_s;
   logic signed [INT_W-1:0]  u_int;
   logic signed [INT_W-1:0]  v_int;
   logic signed [FIX_W-1:0]  u_fix;
   logic signed [FIX_W-1:0]  v_fix;
   logic signed [INT_W-1:0]  red_int;
   logic signed [INT_W-1:0]  green_int;
   logic signed [INT_W-1:0]  blue_int;
   logic signed [FIX_W-1:0]  red_fix;
   logic signed [FIX_W-1:0]  green_fix;
   logic signed [FIX_W-1:0]  blue_fix;
   logic signed [OFF_W-1:0]  red_off;
   logic signed [OFF_W-1:0]  green_off;
   logic signed [OFF_W-1:0]  blue_off;

   // remove the 128 bias: flip the top bit
   assign u_s = $signed({~chroma_blue[BYTE_W-1], chroma_blue[BYTE_W-2:0]});
   assign v_s = $signed({~chroma_red[BYTE_W-1], chroma_red[BYTE_W-2:0]});

   assign u_int = $signed({{(INT_W-BYTE_W){u_s[BYTE_W-1]}}, u_s});
   assign v_int = $signed({{(INT_W-BYTE_W){v_s[BYTE_W-1]}}, v_s});
   assign u_fix = $signed({{(FIX_W-BYTE_W){u_s[BYTE_W-1]}}, u_s});
   assign v_fix = $signed({{(FIX_W-BYTE_W){v_s[BYTE_W-1]}}, v_s});

   assign red_int   = v_int * INT_V_RED;
   assign green_int = u_int * INT_U_GREEN + v_int * INT_V_GREEN;
   assign blue_int  = u_int * INT_U_BLUE;

   assign red_fix   = v_fix * FIX_V_RED;
   assign green_fix = u_fix * FIX_U_GREEN + v_fix * FIX_V_GREEN;
   assign blue_fix  = u_fix * FIX_U_BLUE;

   always_comb begin
      case (mode)
         MODE_INTEGER: begin
            red_off   = $signed(red_int[INT_W-1:INT_SHIFT]);
            green_off = $signed(green_int[INT_W-1:INT_SHIFT]);
            blue_off  = $signed(blue_int[INT_W-1:INT_SHIFT]);
         end
         MODE_FIXED: begin
            red_off   = $signed(red_fix[FIX_W-1:FIX_SHIFT]);
            green_off = $signed(green_fix[FIX_W-1:FIX_SHIFT]);
            blue_off  = $signed(blue_fix[FIX_W-1:FIX_SHIFT]);
         end
         default: begin
            red_off   = '0;
            green_off = '0;
            blue_off  = '0;
         end
      endcase
   end

   assign pixels.red_first    = clamp_byte(luma_first, red_off);
   assign pixels.green_first  = clamp_byte(luma_first, green_off);
   assign pixels.blue_first   = clamp_byte(luma_first, blue_off);
   assign pixels.red_second   = clamp_byte(luma_second, red_off);
   assign pixels.green_second = clamp_byte(luma_second, green_off);
   assign pixels.blue_second  = clamp_byte(luma_second, blue_off);

endmodule

/* dv/yuyv_to_rgba_convert_test.sv */
// Self-checking testbench for yuyv_to_rgba_convert: a random-gap driver, a stalling monitor
// and a YUYV to RGBA predictor compared field by field against every result item.
// Depends on yuyv2rgba_pkg and the yuyv_to_rgba_convert RTL.

module yuyv_to_rgba_convert_test;
   import yuyv2rgba_pkg::*;

   localparam int INT_RED_V   = 90;
   localparam int INT_GREEN_U = -22;
   localparam int INT_GREEN_V = -46;
   localparam int INT_BLUE_U  = 113;
   localparam int Q16_RED_V   = 92242;
   localparam int Q16_GREEN_U = -22580;
   localparam int Q16_GREEN_V = -46983;
   localparam int Q16_BLUE_U  = 116589;
   localparam int COARSE_SHIFT = 6;
   localparam int Q16_SHIFT    = 16;
   localparam int CHROMA_ZERO  = 128;

   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 180;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] chroma_red;
      logic       frame_end;
   } macropixel_type;

   typedef struct packed {
      pixel_pair_type pixels;
      logic [7:0]     alpha;
      logic           frame_end;
   } rgba_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic       csr_index = 1'b0;
   logic [7:0] csr_data = 8'd0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_luma_first = 8'd0;
   logic [7:0] req_chroma_blue = 8'd0;
   logic [7:0] req_luma_second = 8'd0;
   logic [7:0] req_chroma_red = 8'd0;
   logic       req_frame_end_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_red_first;
   logic [7:0] rsp_green_first;
   logic [7:0] rsp_blue_first;
   logic [7:0] rsp_red_second;
   logic [7:0] rsp_green_second;
   logic [7:0] rsp_blue_second;
   logic [7:0] rsp_alpha_out;
   logic       rsp_frame_end_out;

   macropixel_type  pending_items[$];
   rgba_result_type expected_results[$];
   macropixel_type  driven_item = '0;
   mode_type        active_mode = MODE_INTEGER;
   logic [7:0]      active_alpha = ALPHA_RESET;
   int items_queued = 0;
   int results_matched = 0;
   int failures = 0;
   int quiet_cycles = 0;
   int req_hold = 0;
   int rsp_hold = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   yuyv_to_rgba_convert uut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_luma_first(req_luma_first),
      .req_chroma_blue(req_chroma_blue),
      .req_luma_second(req_luma_second),
      .req_chroma_red(req_chroma_red),
      .req_frame_end_in(req_frame_end_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_red_first(rsp_red_first),
      .rsp_green_first(rsp_green_first),
      .rsp_blue_first(rsp_blue_first),
      .rsp_red_second(rsp_red_second),
      .rsp_green_second(rsp_green_second),
      .rsp_blue_second(rsp_blue_second),
      .rsp_alpha_out(rsp_alpha_out),
      .rsp_frame_end_out(rsp_frame_end_out)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic logic [7:0] saturate_channel(int value);
      if (value < 0) return 8'd0;
      if (value > 255) return 8'd255;
      return value[7:0];
   endfunction

   function automatic logic [7:0] fixed_channel(int luma, int coef_u, int u, int coef_v, int v);
      return saturate_channel((luma * 65536 + coef_u * u + coef_v * v) >>> Q16_SHIFT);
   endfunction

   function automatic rgba_result_type convert_macropixel(macropixel_type px);
      rgba_result_type res;
      int y0, y1, u, v, off_r, off_g, off_b;
      y0 = px.luma_first;
      y1 = px.luma_second;
      u = int'(px.chroma_blue) - CHROMA_ZERO;
      v = int'(px.chroma_red) - CHROMA_ZERO;
      if (active_mode == MODE_INTEGER) begin
         off_r = (INT_RED_V * v) >>> COARSE_SHIFT;
         off_g = (INT_GREEN_U * u + INT_GREEN_V * v) >>> COARSE_SHIFT;
         off_b = (INT_BLUE_U * u) >>> COARSE_SHIFT;
         res.pixels.red_first    = saturate_channel(y0 + off_r);
         res.pixels.green_first  = saturate_channel(y0 + off_g);
         res.pixels.blue_first   = saturate_channel(y0 + off_b);
         res.pixels.red_second   = saturate_channel(y1 + off_r);
         res.pixels.green_second = saturate_channel(y1 + off_g);
         res.pixels.blue_second  = saturate_channel(y1 + off_b);
      end else begin
         res.pixels.red_first    = fixed_channel(y0, 0, u, Q16_RED_V, v);
         res.pixels.green_first  = fixed_channel(y0, Q16_GREEN_U, u, Q16_GREEN_V, v);
         res.pixels.blue_first   = fixed_channel(y0, Q16_BLUE_U, u, 0, v);
         res.pixels.red_second   = fixed_channel(y1, 0, u, Q16_RED_V, v);
         res.pixels.green_second = fixed_channel(y1, Q16_GREEN_U, u, Q16_GREEN_V, v);
         res.pixels.blue_second  = fixed_channel(y1, Q16_BLUE_U, u, 0, v);
      end
      res.alpha = active_alpha;
      res.frame_end = px.frame_end;
      return res;
   endfunction

   function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         failures++;
      end
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(0, 15));
         3: return 8'($urandom_range(240, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic macropixel_type random_macropixel();
      macropixel_type px;
      px.luma_first  = pick_byte();
      px.chroma_blue = pick_byte();
      px.luma_second = pick_byte();
      px.chroma_red  = pick_byte();
      px.frame_end   = ($urandom_range(0, 3) == 0);
      return px;
   endfunction

   task automatic queue_item(macropixel_type px);
      pending_items.push_back(px);
      items_queued++;
   endtask

   task automatic queue_directed();
      queue_item(macropixel_type'{8'd0, 8'd0, 8'd0, 8'd0, 1'b0});
      queue_item(macropixel_type'{8'd255, 8'd255, 8'd255, 8'd255, 1'b1});
      queue_item(macropixel_type'{8'd0, 8'd128, 8'd255, 8'd128, 1'b0});
      queue_item(macropixel_type'{8'd128, 8'd128, 8'd128, 8'd128, 1'b1});
      queue_item(macropixel_type'{8'd0, 8'd255, 8'd255, 8'd0, 1'b0});
      queue_item(macropixel_type'{8'd255, 8'd0, 8'd0, 8'd255, 1'b1});
      queue_item(macropixel_type'{8'd16, 8'd127, 8'd235, 8'd129, 1'b0});
      queue_item(macropixel_type'{8'h55, 8'haa, 8'haa, 8'h55, 1'b1});
      queue_item(macropixel_type'{8'haa, 8'h55, 8'h55, 8'haa, 1'b0});
   endtask

   task automatic write_register(csr_index_type idx, logic [7:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      if (idx == CSR_MODE) begin
         active_mode = mode_type'(value[0]);
      end else begin
         active_alpha = value;
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain_results();
      while (results_matched != items_queued) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_hold = 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            expected_results.push_back(convert_macropixel(driven_item));
            if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
            req_hold = req_calm ? 0 : $urandom_range(0, 19);
         end
         if (req_hold == 0 && pending_items.size() != 0) begin
            driven_item = pending_items.pop_front();
            req_valid <= 1'b1;
            req_luma_first <= driven_item.luma_first;
            req_chroma_blue <= driven_item.chroma_blue;
            req_luma_second <= driven_item.luma_second;
            req_chroma_red <= driven_item.chroma_red;
            req_frame_end_in <= driven_item.frame_end;
         end else begin
            req_valid <= 1'b0;
            if (req_hold != 0) req_hold--;
         end
      end
   end

   always @(posedge clock) begin
      rgba_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result item with no macropixel pending");
               failures++;
            end else begin
               want = expected_results.pop_front();
               check_field("red_first", want.pixels.red_first, rsp_red_first);
               check_field("green_first", want.pixels.green_first, rsp_green_first);
               check_field("blue_first", want.pixels.blue_first, rsp_blue_first);
               check_field("red_second", want.pixels.red_second, rsp_red_second);
               check_field("green_second", want.pixels.green_second, rsp_green_second);
               check_field("blue_second", want.pixels.blue_second, rsp_blue_second);
               check_field("alpha_out", want.alpha, rsp_alpha_out);
               check_field("frame_end_out", {7'd0, want.frame_end}, {7'd0, rsp_frame_end_out});
               results_matched++;
            end
            if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
            rsp_hold = rsp_calm ? 0 : $urandom_range(0, 19);
         end
         if (rsp_hold != 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("FAIL yuyv_to_rgba_convert");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase;
      logic [7:0] mode_word;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      queue_directed();
      drain_results();
      write_register(CSR_MODE, 8'hff);
      write_register(CSR_ALPHA, 8'h00);
      queue_directed();
      drain_results();
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         mode_word = 8'($urandom_range(0, 255));
         mode_word[0] = phase[0];
         write_register(CSR_MODE, mode_word);
         if (phase == 0) begin
            write_register(CSR_ALPHA, 8'hff);
         end else if ($urandom_range(0, 1) == 1) begin
            write_register(CSR_ALPHA, 8'($urandom_range(0, 255)));
         end
         repeat (PHASE_ITEMS) queue_item(random_macropixel());
         drain_results();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("PASS yuyv_to_rgba_convert");
      end else begin
         $display("FAIL yuyv_to_rgba_convert");
      end
      $finish;
   end

endmodule

/* files.f */
design/yuyv2rgba_pkg.sv
design/yuyv2rgba_core.sv
design/yuyv_to_rgba_convert.sv
dv/yuyv_to_rgba_convert_test.sv
